// ===== hw/rtl/scjc_pkg.sv =====
// shared types, codes and fixed-point helpers for the jacobian column pipeline
// no dependencies; imported by serial_chain_jacobian_column
package scjc_pkg;

    typedef enum logic [1:0] {
        JT_FIXED     = 2'd0,
        JT_REVOLUTE  = 2'd1,
        JT_PRISMATIC = 2'd2
    } joint_type_t;

    typedef enum logic [1:0] {
        REG_TIP_X = 2'd0,
        REG_TIP_Y = 2'd1,
        REG_TIP_Z = 2'd2
    } cfg_index_t;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned DATA_W      = 32;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [DATA_W:0]   diff_t;      // tip - pos, exact
    typedef logic signed [63:0]       prod_t;      // 32 x 32 product
    typedef logic signed [61:0]       term_t;      // product floored by 2 bits
    typedef logic signed [64:0]       wide_t;

    // cyclic neighbours for the cross products
    localparam int unsigned NXT [3] = '{1, 2, 0};
    localparam int unsigned PRV [3] = '{2, 0, 1};

    // clamp to the signed 32-bit range
    function automatic word_t sat37(input logic signed [36:0] x);
        word_t res;
        if (x > 37'sd2147483647)
            res = 32'sh7fffffff;
        else if (x < -37'sd2147483648)
            res = 32'sh80000000;
        else
            res = x[31:0];
        return res;
    endfunction

    // round half up by 29 fraction bits, then clamp
    function automatic word_t rnd29_sat(input wide_t x);
        wide_t                biased;
        logic signed [35:0]   q;
        biased = x + 65'sd268435456;
        q      = biased[64:29];
        return sat37(37'(q));
    endfunction

endpackage

// ===== hw/rtl/serial_chain_jacobian_column.sv =====
// geometric jacobian column of a serial chain, six-stage pipelined datapath
// depends on scjc_pkg (types, joint and register codes, rounding helpers)
module serial_chain_jacobian_column (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [scjc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    // joint beat
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     joint_type,
    input  logic signed [31:0]             rot_x,
    input  logic signed [31:0]             rot_y,
    input  logic signed [31:0]             rot_z,
    input  logic signed [31:0]             rot_w,
    input  logic signed [31:0]             pos_x,
    input  logic signed [31:0]             pos_y,
    input  logic signed [31:0]             pos_z,
    input  logic signed [31:0]             axis_x,
    input  logic signed [31:0]             axis_y,
    input  logic signed [31:0]             axis_z,
    input  logic                           last_joint,
    // column beat
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           column_valid,
    output logic signed [31:0]             ang_x,
    output logic signed [31:0]             ang_y,
    output logic signed [31:0]             ang_z,
    output logic signed [31:0]             lin_x,
    output logic signed [31:0]             lin_y,
    output logic signed [31:0]             lin_z,
    output logic                           chain_end
);
    // One joint beat in, one column beat out, one beat per cycle sustained
    // while the output is not stalled. The datapath has six register stages;
    // the accepting edge loads the first, and the column then passes through
    // stages two to six, the last of which is the output register:
    //   1  d = tip - pos, first cross-product multipliers u x v
    //   2  t = 2(u x v), rounded and clamped to q1.30
    //   3  second multiplier bank: w*t and the two halves of u x t
    //   4  r = v + w*t + u x t, rounded and clamped (angular part)
    //   5  third multiplier bank: r x d halves, prismatic rescale of r
    //   6  linear part rounded and clamped, joint type selection (output reg)
    // Every stage carries a valid bit and advances whenever it is empty or the
    // stage after it advances, so bubbles collapse and a stalled output holds
    // the whole filled pipe without loss. A fixed joint (and the unused type
    // code) passes through as a column with column_valid low and zero parts;
    // a prismatic joint gives zero angular part and the rotated axis rescaled
    // to q16.16. Config index three is ignored; the user must write the tip
    // registers only while no beat is in flight; the block does not enforce it.

    import scjc_pkg::*;

    // ---------------------------------------------------------------
    // configuration: end-effector position
    // ---------------------------------------------------------------
    word_t tip_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tip_reg[0] <= '0;
            tip_reg[1] <= '0;
            tip_reg[2] <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TIP_X: tip_reg[0] <= cfg_data;
                REG_TIP_Y: tip_reg[1] <= cfg_data;
                REG_TIP_Z: tip_reg[2] <= cfg_data;
                default:   ;    // no register at this index
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pipeline flow control
    // ---------------------------------------------------------------
    logic [6:1] vld_reg;
    logic [6:1] adv;

    // a stage moves on when empty or when the next stage moves on
    always_comb
    begin
        adv[6] = !vld_reg[6] || out_ready;
        for (int k = 5; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready = adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                vld_reg[1] <= in_valid;
            end
            for (int k = 2; k <= 6; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 1: register inputs, d = tip - pos, u x v products
    // ---------------------------------------------------------------
    word_t       in_u [3];
    word_t       in_v [3];
    word_t       in_p [3];
    word_t       s1_u_reg [3];
    word_t       s1_w_reg;
    word_t       s1_v_reg [3];
    diff_t       s1_d_reg [3];
    diff_t       s1_d_next [3];
    prod_t       s1_pa_reg [3];
    prod_t       s1_pb_reg [3];
    prod_t       s1_pa_next [3];
    prod_t       s1_pb_next [3];
    joint_type_t s1_jt_reg;
    logic        s1_last_reg;

    always_comb
    begin
        in_u[0] = rot_x;
        in_u[1] = rot_y;
        in_u[2] = rot_z;
        in_v[0] = axis_x;
        in_v[1] = axis_y;
        in_v[2] = axis_z;
        in_p[0] = pos_x;
        in_p[1] = pos_y;
        in_p[2] = pos_z;
        for (int i = 0; i < 3; i++)
        begin
            s1_d_next[i]  = 33'(tip_reg[i]) - 33'(in_p[i]);
            s1_pa_next[i] = 64'(in_u[NXT[i]]) * 64'(in_v[PRV[i]]);
            s1_pb_next[i] = 64'(in_u[PRV[i]]) * 64'(in_v[NXT[i]]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_u_reg[i]  <= in_u[i];
                s1_v_reg[i]  <= in_v[i];
                s1_d_reg[i]  <= s1_d_next[i];
                s1_pa_reg[i] <= s1_pa_next[i];
                s1_pb_reg[i] <= s1_pb_next[i];
            end
            s1_w_reg    <= rot_w;
            s1_jt_reg   <= joint_type_t'(joint_type);
            s1_last_reg <= last_joint;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: t = 2(u x v), round half up to q1.30 and clamp
    // ---------------------------------------------------------------
    word_t       s2_u_reg [3];
    word_t       s2_w_reg;
    word_t       s2_v_reg [3];
    diff_t       s2_d_reg [3];
    word_t       s2_t_reg [3];
    word_t       s2_t_next [3];
    joint_type_t s2_jt_reg;
    logic        s2_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_t_next[i] = rnd29_sat(65'(s1_pa_reg[i]) - 65'(s1_pb_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_u_reg[i] <= s1_u_reg[i];
                s2_v_reg[i] <= s1_v_reg[i];
                s2_d_reg[i] <= s1_d_reg[i];
                s2_t_reg[i] <= s2_t_next[i];
            end
            s2_w_reg    <= s1_w_reg;
            s2_jt_reg   <= s1_jt_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: w*t and u x t products, each floored by two bits
    // ---------------------------------------------------------------
    word_t       s3_v_reg [3];
    diff_t       s3_d_reg [3];
    term_t       s3_qa_reg [3];
    term_t       s3_qb_reg [3];
    term_t       s3_qc_reg [3];
    prod_t       s3_qa_full [3];
    prod_t       s3_qb_full [3];
    prod_t       s3_qc_full [3];
    joint_type_t s3_jt_reg;
    logic        s3_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_qa_full[i] = 64'(s2_w_reg) * 64'(s2_t_reg[i]);
            s3_qb_full[i] = 64'(s2_u_reg[NXT[i]]) * 64'(s2_t_reg[PRV[i]]);
            s3_qc_full[i] = 64'(s2_u_reg[PRV[i]]) * 64'(s2_t_reg[NXT[i]]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s3_v_reg[i]  <= s2_v_reg[i];
                s3_d_reg[i]  <= s2_d_reg[i];
                s3_qa_reg[i] <= s3_qa_full[i][63:2];
                s3_qb_reg[i] <= s3_qb_full[i][63:2];
                s3_qc_reg[i] <= s3_qc_full[i][63:2];
            end
            s3_jt_reg   <= s2_jt_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: r = v + round(sum), clamped to q1.30
    // ---------------------------------------------------------------
    diff_t              s4_d_reg [3];
    word_t              s4_r_reg [3];
    word_t              s4_r_next [3];
    prod_t              s4_sum [3];
    prod_t              s4_biased [3];
    logic signed [35:0] s4_rounded [3];
    joint_type_t        s4_jt_reg;
    logic               s4_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s4_sum[i]     = 64'(s3_qa_reg[i]) + 64'(s3_qb_reg[i]) - 64'(s3_qc_reg[i]);
            s4_biased[i]  = s4_sum[i] + 64'sd134217728;
            s4_rounded[i] = s4_biased[i][63:28];
            s4_r_next[i]  = sat37(37'(s4_rounded[i]) + 37'(s3_v_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_d_reg[i] <= s3_d_reg[i];
                s4_r_reg[i] <= s4_r_next[i];
            end
            s4_jt_reg   <= s3_jt_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 5: r x d halves floored by one bit, prismatic rescale
    // ---------------------------------------------------------------
    word_t              s5_r_reg [3];
    prod_t              s5_la_reg [3];
    prod_t              s5_lb_reg [3];
    word_t              s5_prism_reg [3];
    wide_t              s5_la_full [3];
    wide_t              s5_lb_full [3];
    logic signed [32:0] s5_pr_biased [3];
    logic signed [18:0] s5_pr_q [3];
    joint_type_t        s5_jt_reg;
    logic               s5_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s5_la_full[i]   = 65'(s4_r_reg[NXT[i]]) * 65'(s4_d_reg[PRV[i]]);
            s5_lb_full[i]   = 65'(s4_r_reg[PRV[i]]) * 65'(s4_d_reg[NXT[i]]);
            // q1.30 to q16.16, round half up
            s5_pr_biased[i] = 33'(s4_r_reg[i]) + 33'sd8192;
            s5_pr_q[i]      = s5_pr_biased[i][32:14];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s5_r_reg[i]     <= s4_r_reg[i];
                s5_la_reg[i]    <= s5_la_full[i][64:1];
                s5_lb_reg[i]    <= s5_lb_full[i][64:1];
                s5_prism_reg[i] <= 32'(s5_pr_q[i]);
            end
            s5_jt_reg   <= s4_jt_reg;
            s5_last_reg <= s4_last_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 6: linear part and joint type selection, output register
    // ---------------------------------------------------------------
    word_t ang_reg [3];
    word_t ang_next [3];
    word_t lin_reg [3];
    word_t lin_next [3];
    logic  col_vld_reg;
    logic  col_vld_next;
    logic  chain_end_reg;

    always_comb
    begin
        col_vld_next = (s5_jt_reg == JT_REVOLUTE) || (s5_jt_reg == JT_PRISMATIC);
        for (int i = 0; i < 3; i++)
        begin
            case (s5_jt_reg)
                JT_REVOLUTE:
                begin
                    ang_next[i] = s5_r_reg[i];
                    lin_next[i] = rnd29_sat(65'(s5_la_reg[i]) - 65'(s5_lb_reg[i]));
                end
                JT_PRISMATIC:
                begin
                    ang_next[i] = '0;
                    lin_next[i] = s5_prism_reg[i];
                end
                default:
                begin
                    // fixed joint or unused code: empty column
                    ang_next[i] = '0;
                    lin_next[i] = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            for (int i = 0; i < 3; i++)
            begin
                ang_reg[i] <= ang_next[i];
                lin_reg[i] <= lin_next[i];
            end
            col_vld_reg   <= col_vld_next;
            chain_end_reg <= s5_last_reg;
        end
    end

    assign out_valid    = vld_reg[6];
    assign column_valid = col_vld_reg;
    assign ang_x        = ang_reg[0];
    assign ang_y        = ang_reg[1];
    assign ang_z        = ang_reg[2];
    assign lin_x        = lin_reg[0];
    assign lin_y        = lin_reg[1];
    assign lin_z        = lin_reg[2];
    assign chain_end    = chain_end_reg;

endmodule
